// ===== hdl/ids_pkg.sv =====
// Shared constants, types and the arctangent table for the isotropic direction sampler.
// No dependencies.
package ids_pkg;

	localparam int OUT_FRAC_BITS = 30;
	localparam int CORDIC_STAGES = 24;
	localparam int SQ_STEPS      = OUT_FRAC_BITS + 1;
	localparam int ANG_W         = 34;
	localparam int ROOT_W        = OUT_FRAC_BITS + 1;
	localparam logic [31:0] INV_GAIN = 32'd2608131496;

	// handed from the front end to the CORDIC
	typedef struct packed {
		logic [ROOT_W-1:0]       sin_t;
		logic signed [ANG_W-1:0] ang;
		logic                    flip;
		logic signed [31:0]      z;
	} ids_front_t;

	// handed from the CORDIC to the finishing stages
	typedef struct packed {
		logic signed [63:0] x;
		logic signed [63:0] y;
		logic               flip;
		logic signed [31:0] z;
	} ids_rot_t;

	// atan(2^-i) in units of 2^-32 turn, rounded
	function automatic logic [31:0] atan_turn(input int i);
		logic [31:0] r;
		case (i)
			0: r = 32'd536870912;   1: r = 32'd316933406;   2: r = 32'd167458907;
			3: r = 32'd85004756;    4: r = 32'd42667331;    5: r = 32'd21354465;
			6: r = 32'd10679838;    7: r = 32'd5340245;     8: r = 32'd2670163;
			9: r = 32'd1335087;     10: r = 32'd667544;     11: r = 32'd333772;
			12: r = 32'd166886;     13: r = 32'd83443;      14: r = 32'd41722;
			15: r = 32'd20861;      16: r = 32'd10430;      17: r = 32'd5215;
			18: r = 32'd2608;       19: r = 32'd1304;       20: r = 32'd652;
			21: r = 32'd326;        22: r = 32'd163;        23: r = 32'd81;
			24: r = 32'd41;         25: r = 32'd20;         26: r = 32'd10;
			27: r = 32'd5;          28: r = 32'd3;          29: r = 32'd1;
			30: r = 32'd1;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/ids_in_if.sv =====
// Input channel of the direction sampler: two uniform fractions.
// No dependencies.
interface ids_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] u_polar;
	logic [31:0] u_azimuth;

	modport source (output valid, output u_polar, output u_azimuth, input ready);
	modport sink (input valid, input u_polar, input u_azimuth, output ready);
endinterface

// ===== hdl/ids_out_if.sv =====
// Output channel of the direction sampler: one unit vector in Q1.30.
// No dependencies.
interface ids_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] dir_x;
	logic signed [31:0] dir_y;
	logic signed [31:0] dir_z;

	modport source (output valid, output dir_x, output dir_y, output dir_z, input ready);
	modport sink (input valid, input dir_x, input dir_y, input dir_z, output ready);
endinterface

// ===== hdl/isotropic_direction_sampler.sv =====
// Isotropic direction sampler: uniform fractions in, unit vector (Q1.30) out.
// Pipeline: front end (z, z squared, root argument), square root, CORDIC, then the finishing stages.
// One transfer per cycle unless stalled; square root and CORDIC each take one step per stage.
// A stall at the output holds the whole pipeline; ready follows it combinationally.
// Reset (arst_n, asynchronous) clears every stage valid bit; the pipeline then accepts at once.
module isotropic_direction_sampler (
	input logic clk,
	input logic arst_n,
	ids_in_if.sink    sample_in,
	ids_out_if.source dir_out
);
	import ids_pkg::*;

	logic       adv;
	logic       fr_valid, cr_valid;
	ids_front_t fr_data;
	ids_rot_t   cr_data;

	assign adv             = !dir_out.valid || dir_out.ready;
	assign sample_in.ready = adv;

	ids_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (sample_in.valid),
		.u_polar   (sample_in.u_polar),
		.u_azimuth (sample_in.u_azimuth),
		.out_valid (fr_valid),
		.out_data  (fr_data)
	);

	ids_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (fr_valid),
		.in_data   (fr_data),
		.out_valid (cr_valid),
		.out_data  (cr_data)
	);

	ids_finish u_finish (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (cr_valid),
		.in_data   (cr_data),
		.out_valid (dir_out.valid),
		.dir_x     (dir_out.dir_x),
		.dir_y     (dir_out.dir_y),
		.dir_z     (dir_out.dir_z)
	);

	localparam logic signed [31:0] ONE = 32'sd1 <<< OUT_FRAC_BITS;

	a_x_range: assert property (@(posedge clk) disable iff (!arst_n)
		dir_out.valid |-> (dir_out.dir_x <= ONE && dir_out.dir_x >= -ONE))
		else $error("dir_x outside unit range");

	a_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		dir_out.valid |-> (dir_out.dir_y <= ONE && dir_out.dir_y >= -ONE))
		else $error("dir_y outside unit range");

	a_z_range: assert property (@(posedge clk) disable iff (!arst_n)
		dir_out.valid |-> (dir_out.dir_z < ONE && dir_out.dir_z >= -ONE))
		else $error("dir_z outside range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(dir_out.valid && !dir_out.ready) |=> (dir_out.valid && !sample_in.ready
			|| dir_out.ready))
		else $error("output lost during stall");

endmodule

// ===== hdl/ids_front.sv =====
// Front end: z, z squared, clamped root argument and a pipelined integer square root.
// Depends on ids_pkg.
module ids_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [31:0]         u_polar,
	input  logic [31:0]         u_azimuth,
	output logic                out_valid,
	output ids_pkg::ids_front_t out_data
);
	import ids_pkg::*;

	logic                    v_s1, v_s2, v_s3;
	logic signed [31:0]      z_s1, z_s2, z_s3;
	logic signed [ANG_W-1:0] ang_s1, ang_s2, ang_s3;
	logic                    flip_s1, flip_s2, flip_s3;
	logic signed [63:0]      zsq_s2;
	logic [63:0]             arg_s3;
	logic [31:0]             a_turn;
	logic [31:0]             a_fold;
	logic                    a_flip;
	logic signed [63:0]      arg_full;

	assign a_turn = u_azimuth + 32'h4000_0000;
	assign a_flip = a_turn[31];
	assign a_fold = u_azimuth ^ {a_flip, 31'd0};
	assign arg_full = (64'sd1 <<< (2 * OUT_FRAC_BITS)) - zsq_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s1    <= 32'($signed({1'b0, u_polar >> (31 - OUT_FRAC_BITS)}))
				- (32'sd1 <<< OUT_FRAC_BITS);
			ang_s1  <= ANG_W'($signed(a_fold));
			flip_s1 <= a_flip;
			zsq_s2  <= 64'(z_s1) * 64'(z_s1);
			z_s2    <= z_s1;
			ang_s2  <= ang_s1;
			flip_s2 <= flip_s1;
			arg_s3  <= arg_full[63] ? 64'd0 : 64'(arg_full);
			z_s3    <= z_s2;
			ang_s3  <= ang_s2;
			flip_s3 <= flip_s2;
		end
	end

	// digit-by-digit square root, one result bit per stage
	logic                    sq_v_s   [SQ_STEPS+1];
	logic [63:0]             sq_rem_s [SQ_STEPS+1];
	logic [63:0]             sq_root_s[SQ_STEPS+1];
	logic signed [31:0]      sq_z_s   [SQ_STEPS+1];
	logic signed [ANG_W-1:0] sq_ang_s [SQ_STEPS+1];
	logic                    sq_flip_s[SQ_STEPS+1];

	assign sq_v_s[0]    = v_s3;
	assign sq_rem_s[0]  = arg_s3;
	assign sq_root_s[0] = 64'd0;
	assign sq_z_s[0]    = z_s3;
	assign sq_ang_s[0]  = ang_s3;
	assign sq_flip_s[0] = flip_s3;

	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
		localparam logic [63:0] BIT = 64'd1 << (2 * (OUT_FRAC_BITS - k));
		logic [63:0] trial;
		logic        take;

		assign trial = sq_root_s[k] + BIT;
		assign take  = sq_rem_s[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k+1] <= 1'b0;
			end else if (en) begin
				sq_v_s[k+1] <= sq_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_rem_s[k+1]  <= take ? sq_rem_s[k] - trial : sq_rem_s[k];
				sq_root_s[k+1] <= take ? (sq_root_s[k] >> 1) + BIT : sq_root_s[k] >> 1;
				sq_z_s[k+1]    <= sq_z_s[k];
				sq_ang_s[k+1]  <= sq_ang_s[k];
				sq_flip_s[k+1] <= sq_flip_s[k];
			end
		end
	end

	assign out_valid      = sq_v_s[SQ_STEPS];
	assign out_data.sin_t = sq_root_s[SQ_STEPS][ROOT_W-1:0];
	assign out_data.ang   = sq_ang_s[SQ_STEPS];
	assign out_data.flip  = sq_flip_s[SQ_STEPS];
	assign out_data.z     = sq_z_s[SQ_STEPS];

endmodule

// ===== hdl/ids_cordic.sv =====
// Rotation-mode CORDIC, one micro-rotation per stage, start vector (polar sine, 0).
// Depends on ids_pkg.
module ids_cordic (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  ids_pkg::ids_front_t in_data,
	output logic                out_valid,
	output ids_pkg::ids_rot_t   out_data
);
	import ids_pkg::*;

	logic                    cr_v_s   [CORDIC_STAGES+1];
	logic signed [63:0]      cr_x_s   [CORDIC_STAGES+1];
	logic signed [63:0]      cr_y_s   [CORDIC_STAGES+1];
	logic signed [ANG_W-1:0] cr_ang_s [CORDIC_STAGES+1];
	logic                    cr_flip_s[CORDIC_STAGES+1];
	logic signed [31:0]      cr_z_s   [CORDIC_STAGES+1];

	assign cr_v_s[0]    = in_valid;
	assign cr_x_s[0]    = $signed({{(64-ROOT_W-30){1'b0}}, in_data.sin_t, 30'd0});
	assign cr_y_s[0]    = 64'sd0;
	assign cr_ang_s[0]  = in_data.ang;
	assign cr_flip_s[0] = in_data.flip;
	assign cr_z_s[0]    = in_data.z;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_rot
		localparam logic signed [ANG_W-1:0] ATAN = ANG_W'(atan_turn(i));
		logic signed [63:0] dx, dy;
		logic               pos;

		assign dx  = cr_y_s[i] >>> i;
		assign dy  = cr_x_s[i] >>> i;
		assign pos = !cr_ang_s[i][ANG_W-1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cr_v_s[i+1] <= 1'b0;
			end else if (en) begin
				cr_v_s[i+1] <= cr_v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cr_x_s[i+1]    <= pos ? cr_x_s[i] - dx : cr_x_s[i] + dx;
				cr_y_s[i+1]    <= pos ? cr_y_s[i] + dy : cr_y_s[i] - dy;
				cr_ang_s[i+1]  <= pos ? cr_ang_s[i] - ATAN : cr_ang_s[i] + ATAN;
				cr_flip_s[i+1] <= cr_flip_s[i];
				cr_z_s[i+1]    <= cr_z_s[i];
			end
		end
	end

	assign out_valid     = cr_v_s[CORDIC_STAGES];
	assign out_data.x    = cr_x_s[CORDIC_STAGES];
	assign out_data.y    = cr_y_s[CORDIC_STAGES];
	assign out_data.flip = cr_flip_s[CORDIC_STAGES];
	assign out_data.z    = cr_z_s[CORDIC_STAGES];

endmodule

// ===== hdl/ids_finish.sv =====
// Gain correction, rounding, clamping and sign restore; last stage is the output register.
// Depends on ids_pkg.
module ids_finish (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  ids_pkg::ids_rot_t  in_data,
	output logic               out_valid,
	output logic signed [31:0] dir_x,
	output logic signed [31:0] dir_y,
	output logic signed [31:0] dir_z
);
	import ids_pkg::*;

	localparam logic [63:0] LIM  = 64'd1 << OUT_FRAC_BITS;
	localparam logic [63:0] HALF = 64'd1 << 29;

	logic               v_s1, v_s2, v_s3;
	logic [63:0]        mx_s1, my_s1;
	logic               nx_s1, ny_s1, nx_s2, ny_s2;
	logic signed [31:0] z_s1, z_s2;
	logic [63:0]        phx_s2, plx_s2, phy_s2, ply_s2;
	logic [63:0]        px, py, rx, ry, cx, cy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// sum of partial products, then round half away from zero on the magnitude
	assign px = phx_s2 + (plx_s2 >> 32);
	assign py = phy_s2 + (ply_s2 >> 32);
	assign rx = (px + HALF) >> 30;
	assign ry = (py + HALF) >> 30;
	assign cx = (rx > LIM) ? LIM : rx;
	assign cy = (ry > LIM) ? LIM : ry;

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1  <= in_data.x[63] ? 64'(-in_data.x) : 64'(in_data.x);
			my_s1  <= in_data.y[63] ? 64'(-in_data.y) : 64'(in_data.y);
			nx_s1  <= in_data.x[63] ^ in_data.flip;
			ny_s1  <= in_data.y[63] ^ in_data.flip;
			z_s1   <= in_data.z;
			phx_s2 <= 64'(mx_s1[63:32]) * 64'(INV_GAIN);
			plx_s2 <= 64'(mx_s1[31:0]) * 64'(INV_GAIN);
			phy_s2 <= 64'(my_s1[63:32]) * 64'(INV_GAIN);
			ply_s2 <= 64'(my_s1[31:0]) * 64'(INV_GAIN);
			nx_s2  <= nx_s1;
			ny_s2  <= ny_s1;
			z_s2   <= z_s1;
			dir_x  <= nx_s2 ? -$signed(cx[31:0]) : $signed(cx[31:0]);
			dir_y  <= ny_s2 ? -$signed(cy[31:0]) : $signed(cy[31:0]);
			dir_z  <= z_s2;
		end
	end

	assign out_valid = v_s3;

endmodule
